[src/mmpq_pkg.sv]
// Shared types and codes for the min/max priority queue.
// Holds the request/result words and the per-cell control word; no dependencies.
`default_nettype none

package mmpq_pkg;

	localparam int VAL_W   = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [VAL_W-1:0]  value;
	} request_t;

	typedef struct packed {
		status_t                  status;
		logic                     low_valid;
		logic signed [VAL_W-1:0]  low_value;
		logic                     high_valid;
		logic signed [VAL_W-1:0]  high_value;
		logic [COUNT_W-1:0]       entry_count;
	} result_t;

	// Row-wide control broadcast to every cell
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[src/mmpq_cell.sv]
// One storage cell of the sorted row: holds a value and trades it with its neighbors.
// Depends on mmpq_pkg for the value width and the row control word.
`default_nettype none

module mmpq_cell (
	input  wire                               clk,
	input  mmpq_pkg::cell_ctrl_t              ctrl,
	input  wire                               occupied,
	input  wire signed [mmpq_pkg::VAL_W-1:0]  new_value,
	input  wire signed [mmpq_pkg::VAL_W-1:0]  left_value,
	input  wire                               left_lt,
	input  wire signed [mmpq_pkg::VAL_W-1:0]  right_value,
	output logic signed [mmpq_pkg::VAL_W-1:0] value_q,
	output logic                              lt
);
	import mmpq_pkg::*;

	logic signed [VAL_W-1:0] value_d;

	// Flag a held value that sorts before the incoming one
	assign lt = occupied && (value_q < new_value);

	// Keep, take the new value, shift right on insert; shift left on remove
	always_comb begin
		value_d = value_q;
		if (ctrl.insert) begin
			if (lt) begin
				value_d = value_q;
			end else if (left_lt) begin
				value_d = new_value;
			end else begin
				value_d = left_value;
			end
		end else if (ctrl.remove) begin
			value_d = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

`default_nettype wire

[src/min_max_priority_queue_core.sv]
// Double-ended priority queue on a row of sorted cells.
// The result word and done are registered: they appear in the cycle after the request is taken (done high one cycle).
// Throughput: one request per cycle; busy stays low, since every cell decides its next
// value from its neighbors in the same cycle; the high pick is an AND-OR over the row.
// Reset clears the fill count and the strobe; cell contents are not reset.
// The receiver cannot stall: each result word is valid for exactly one cycle.
`default_nettype none

module min_max_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  mmpq_pkg::request_t request,
	output logic               done,
	output mmpq_pkg::result_t  result
);
	import mmpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic                     done_q;
	result_t                  result_q;
	result_t                  result_d;
	logic                     accept;
	logic                     is_full;
	cell_ctrl_t               ctrl;
	logic signed [VAL_W-1:0]  cell_value [CAPACITY];
	logic [CAPACITY-1:0]      cell_lt;
	logic [CAPACITY:0]        occ;
	logic [CAPACITY-1:0]      last_hit;
	logic signed [VAL_W-1:0]  high_pick;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign is_full = (count_q == CW'(CAPACITY));

	// Decode the request into row-wide shift controls
	always_comb begin
		ctrl.insert = accept && (request.command == CMD_INSERT) && !is_full;
		ctrl.remove = accept && (request.command == CMD_REMOVE) && (count_q >= CW'(2));
	end

	// Build the cell row
	assign occ[CAPACITY] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;
		logic                    left_lt;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_v  = request.value;
			assign left_lt = 1'b1;
		end else begin : g_mid
			assign left_v  = cell_value[i-1];
			assign left_lt = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_inner
			assign right_v = cell_value[i+1];
		end

		mmpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ[i]),
			.new_value   (request.value),
			.left_value  (left_v),
			.left_lt     (left_lt),
			.right_value (right_v),
			.value_q     (cell_value[i]),
			.lt          (cell_lt[i])
		);

		// Mark the topmost occupied cell
		assign last_hit[i] = occ[i] && !occ[i+1];
	end

	// Select the largest stored value
	always_comb begin
		high_pick = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			high_pick = high_pick | (last_hit[k] ? cell_value[k] : '0);
		end
	end

	// Form the next count and the result word
	always_comb begin
		count_d              = count_q;
		result_d.status      = ST_DONE;
		result_d.low_valid   = 1'b0;
		result_d.low_value   = '0;
		result_d.high_valid  = 1'b0;
		result_d.high_value  = '0;
		if (request.command == CMD_INSERT) begin
			if (is_full) begin
				result_d.status = ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else begin
			if (count_q == '0) begin
				result_d.status = ST_EMPTY;
			end else if (count_q == CW'(1)) begin
				result_d.low_valid = 1'b1;
				result_d.low_value = cell_value[0];
				count_d            = '0;
			end else begin
				result_d.low_valid  = 1'b1;
				result_d.low_value  = cell_value[0];
				result_d.high_valid = 1'b1;
				result_d.high_value = high_pick;
				count_d             = count_q - CW'(2);
			end
		end
		result_d.entry_count = COUNT_W'({{COUNT_W{1'b0}}, count_d});
	end

	// Hold the fill count and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// Register the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Fill count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	// A strobe only follows a taken request
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result strobe without request");

	// A largest value is never reported without a smallest
	a_high_needs_low: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.high_valid |-> result.low_valid)
		else $error("high reported without low");

	// Reported pair is ordered
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.high_valid |-> (result.low_value <= result.high_value))
		else $error("low above high");

	// A dropped insert leaves the row full
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("insert dropped while not full");

endmodule

`default_nettype wire
